// ===== rtl/core/chs_pkg.sv =====
// Shared types and constants for the CHS sector address translator.
package chs_pkg;

  localparam int ADDRESS_BITS = 30;
  localparam int CYL_W        = 16;
  localparam int HEAD_W       = 4;
  localparam int SECT_W       = 8;
  localparam int HEADS_W      = 5;
  localparam int SPT_W        = 8;
  localparam int LIN_W        = 30;
  localparam int ACC_W        = (ADDRESS_BITS + 1 > LIN_W + SPT_W) ?
                                (ADDRESS_BITS + 1) : (LIN_W + SPT_W);
  localparam int CNT_W        = $clog2(LIN_W + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG_SPT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_HEADS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHY_SPT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHY_HEADS = 2'd3;

  localparam logic [0:0] KIND_LOAD = 1'b0;

  typedef struct packed {
    logic [0:0]        kind;
    logic [CYL_W-1:0]  load_cylinder;
    logic [HEAD_W-1:0] load_head;
    logic [SECT_W-1:0] load_sector;
  } in_word_t;

  typedef struct packed {
    logic [CYL_W-1:0]        cur_cylinder;
    logic [HEAD_W-1:0]       cur_head;
    logic [SECT_W-1:0]       cur_sector;
    logic [ADDRESS_BITS-1:0] sector_address;
    logic [0:0]              out_of_range;
  } out_word_t;

  typedef struct packed {
    logic [SPT_W-1:0]   log_spt;
    logic [HEADS_W-1:0] log_heads;
    logic [SPT_W-1:0]   phy_spt;
    logic [HEADS_W-1:0] phy_heads;
  } geom_t;

  typedef struct packed {
    logic [CYL_W-1:0]  cylinder;
    logic [HEAD_W-1:0] head;
    logic [SECT_W-1:0] sector;
  } pos_t;

  typedef enum logic [2:0] {
    CALC_IDLE,
    CALC_MUL_HEAD,
    CALC_MUL_SPT,
    CALC_DIV,
    CALC_MUL_PHYS,
    CALC_DONE
  } calc_state_t;

endpackage

// ===== rtl/core/chs_addr_unit.sv =====
// Bit-serial address unit: shift-add multiplies and restoring division.
module chs_addr_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  chs_pkg::geom_t                geom,
  input  chs_pkg::pos_t                 pos,
  input  logic                          ack,
  output logic                          busy,
  output logic                          done,
  output logic [chs_pkg::ADDRESS_BITS-1:0] addr,
  output logic                          bad_out
);
  import chs_pkg::*;

  calc_state_t       state, state_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [ACC_W-1:0]  mcand, mcand_next;
  logic [SPT_W-1:0]  mplier, mplier_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [SPT_W-1:0]  rem, rem_next;
  logic [LIN_W-1:0]  quo, quo_next;
  logic              bad, bad_next;

  logic [ACC_W-1:0]  acc_sum;
  logic [SPT_W:0]    rem_s;
  logic [SPT_W-1:0]  used;
  logic              ge;
  logic [SPT_W-1:0]  rem_d;
  logic [LIN_W-1:0]  quo_d;
  logic              range_bad;
  logic              xlate;
  logic              last;
  logic              ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CALC_IDLE;
    end else begin
      state <= state_next;
    end
    acc    <= acc_next;
    mcand  <= mcand_next;
    mplier <= mplier_next;
    cnt    <= cnt_next;
    rem    <= rem_next;
    quo    <= quo_next;
    bad    <= bad_next;
  end

  assign acc_sum = acc + (mplier[0] ? mcand : '0);
  assign rem_s   = {rem, quo[LIN_W-1]};
  assign used    = geom.phy_spt - SPT_W'(1);
  assign ge      = rem_s >= {1'b0, used};
  assign rem_d   = ge ? SPT_W'(rem_s - {1'b0, used}) : SPT_W'(rem_s);
  assign quo_d   = {quo[LIN_W-2:0], ge};
  assign last    = cnt == CNT_W'(1);

  assign range_bad = ({1'b0, pos.head} >= geom.log_heads) || (pos.sector == '0) ||
                     (pos.sector > geom.log_spt);
  assign xlate     = (geom.log_spt != geom.phy_spt) || (geom.log_heads != geom.phy_heads);

  always_comb begin
    state_next  = state;
    acc_next    = acc;
    mcand_next  = mcand;
    mplier_next = mplier;
    cnt_next    = cnt;
    rem_next    = rem;
    quo_next    = quo;
    bad_next    = bad;
    unique case (state)
      CALC_IDLE: begin
        if (start) begin
          bad_next = range_bad || (xlate && (geom.phy_spt < SPT_W'(2)));
          if (range_bad || (xlate && (geom.phy_spt < SPT_W'(2)))) begin
            state_next = CALC_DONE;
          end else begin
            acc_next    = ACC_W'(pos.head);
            mcand_next  = ACC_W'(pos.cylinder);
            mplier_next = SPT_W'(geom.log_heads);
            cnt_next    = CNT_W'(HEADS_W);
            state_next  = CALC_MUL_HEAD;
          end
        end
      end
      CALC_MUL_HEAD: begin
        acc_next    = acc_sum;
        mcand_next  = mcand << 1;
        mplier_next = mplier >> 1;
        cnt_next    = cnt - CNT_W'(1);
        if (last) begin
          // c*heads+h done; now times sectors per track plus sector-1
          mcand_next  = acc_sum;
          acc_next    = ACC_W'(pos.sector - SECT_W'(1));
          mplier_next = geom.log_spt;
          cnt_next    = CNT_W'(SPT_W);
          state_next  = CALC_MUL_SPT;
        end
      end
      CALC_MUL_SPT: begin
        acc_next    = acc_sum;
        mcand_next  = mcand << 1;
        mplier_next = mplier >> 1;
        cnt_next    = cnt - CNT_W'(1);
        if (last) begin
          if (xlate) begin
            quo_next   = acc_sum[LIN_W-1:0];
            rem_next   = '0;
            cnt_next   = CNT_W'(LIN_W);
            state_next = CALC_DIV;
          end else begin
            state_next = CALC_DONE;
          end
        end
      end
      CALC_DIV: begin
        rem_next = rem_d;
        quo_next = quo_d;
        cnt_next = cnt - CNT_W'(1);
        if (last) begin
          // quotient*pspt + remainder
          acc_next    = ACC_W'(rem_d);
          mcand_next  = ACC_W'(quo_d);
          mplier_next = geom.phy_spt;
          cnt_next    = CNT_W'(SPT_W);
          state_next  = CALC_MUL_PHYS;
        end
      end
      CALC_MUL_PHYS: begin
        acc_next    = acc_sum;
        mcand_next  = mcand << 1;
        mplier_next = mplier >> 1;
        cnt_next    = cnt - CNT_W'(1);
        if (last) begin
          state_next = CALC_DONE;
        end
      end
      CALC_DONE: begin
        if (ack) begin
          state_next = CALC_IDLE;
        end
      end
      default: begin
        state_next = CALC_IDLE;
      end
    endcase
  end

  assign busy    = state != CALC_IDLE;
  assign done    = state == CALC_DONE;
  assign ovf     = |acc[ACC_W-1:ADDRESS_BITS];
  assign bad_out = bad || ovf;
  assign addr    = bad_out ? '0 : acc[ADDRESS_BITS-1:0];

endmodule

// ===== rtl/core/chs_sector_address_translator.sv =====
// Top level of the CHS sector address translator.
//
// Input words on in_data (valid/stall) either load a cylinder/head/sector
// position or step it to the next sector. Each input word yields one output
// word on out_data with the new position, its linear sector address and an
// out_of_range flag; the address is zero when the flag is set.
// Geometry registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle, which it does not enforce.
// The address is built by a bit-serial unit: a shift-add multiply by the
// head count, one by the sectors per track, and when the logical and
// physical geometry differ, a restoring division by the used sectors per
// track (physical minus one) and a multiply back. An out-of-range position
// skips the arithmetic. in_stall stays high from acceptance until the result
// is loaded into the output register, so no new word is taken before that.
// The output register lets the unit finish while out_stall is high; the
// unit then holds its result and in_stall stays high until it is taken.
// Reset restores the default geometry (17 sectors, 16 heads) and the
// position cylinder 0, head 0, sector 1; in_stall is high during reset.
module chs_sector_address_translator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  chs_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output chs_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [chs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import chs_pkg::*;

  geom_t             geom;
  pos_t              pos, pos_next;
  logic              start_q;
  logic              in_fire;
  logic              load_out;
  logic              calc_busy;
  logic              calc_done;
  logic [ADDRESS_BITS-1:0] calc_addr;
  logic              calc_bad;
  logic [SECT_W:0]   sect_inc;
  logic [HEADS_W-1:0] head_inc;

  assign in_stall = rst || start_q || calc_busy;
  assign in_fire  = in_valid && !in_stall;
  assign load_out = calc_done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.log_spt   <= SPT_W'(17);
      geom.log_heads <= HEADS_W'(16);
      geom.phy_spt   <= SPT_W'(17);
      geom.phy_heads <= HEADS_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOG_SPT:   geom.log_spt   <= cfg_data;
        CFG_LOG_HEADS: geom.log_heads <= cfg_data[HEADS_W-1:0];
        CFG_PHY_SPT:   geom.phy_spt   <= cfg_data;
        CFG_PHY_HEADS: geom.phy_heads <= cfg_data[HEADS_W-1:0];
        default: ;
      endcase
    end
  end

  // sector wraps only on reaching exactly spt+1, head only on exactly heads
  assign sect_inc = {1'b0, pos.sector} + (SECT_W+1)'(1);
  assign head_inc = {1'b0, pos.head} + HEADS_W'(1);

  always_comb begin
    pos_next = pos;
    if (in_data.kind == KIND_LOAD) begin
      pos_next.cylinder = in_data.load_cylinder;
      pos_next.head     = in_data.load_head;
      pos_next.sector   = in_data.load_sector;
    end else if (sect_inc == ({1'b0, geom.log_spt} + (SECT_W+1)'(1))) begin
      pos_next.sector = SECT_W'(1);
      if (head_inc == geom.log_heads) begin
        pos_next.head     = '0;
        pos_next.cylinder = pos.cylinder + CYL_W'(1);
      end else begin
        pos_next.head = head_inc[HEAD_W-1:0];
      end
    end else begin
      pos_next.sector = sect_inc[SECT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos.cylinder <= '0;
      pos.head     <= '0;
      pos.sector   <= SECT_W'(1);
      start_q      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        pos <= pos_next;
      end
      start_q <= in_fire;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.cur_cylinder   <= pos.cylinder;
      out_data.cur_head       <= pos.head;
      out_data.cur_sector     <= pos.sector;
      out_data.sector_address <= calc_addr;
      out_data.out_of_range   <= calc_bad;
    end
  end

  chs_addr_unit u_addr (
    .clk     (clk),
    .rst     (rst),
    .start   (start_q),
    .geom    (geom),
    .pos     (pos),
    .ack     (load_out),
    .busy    (calc_busy),
    .done    (calc_done),
    .addr    (calc_addr),
    .bad_out (calc_bad)
  );

endmodule

// ===== verif/chs_sector_address_translator_tb.sv =====
// Self-checking testbench for the CHS sector address translator.
module chs_sector_address_translator_tb;
  import chs_pkg::*;

  localparam logic [0:0] KIND_STEP   = 1'b1;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         TAIL_CYCLES = 64;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SCATTERED,
    STALL_LONG
  } stall_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOG_SPT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Geometry and position as the block should hold them
  logic [SPT_W-1:0]   geo_lspt   = 8'd17;
  logic [HEADS_W-1:0] geo_lheads = 5'd16;
  logic [SPT_W-1:0]   geo_pspt   = 8'd17;
  logic [HEADS_W-1:0] geo_pheads = 5'd16;
  logic [CYL_W-1:0]   pos_cyl    = '0;
  logic [HEAD_W-1:0]  pos_head   = '0;
  logic [SECT_W-1:0]  pos_sect   = 8'd1;

  out_word_t   pending_addresses[$];
  out_word_t   oldest_address;
  int          mismatches      = 0;
  int          words_sent      = 0;
  int          results_checked = 0;
  int          flagged_results = 0;
  int          geometries_used = 0;
  int          cycle_count     = 0;
  int          burst_left      = 0;
  bit          steady_traffic  = 1'b0;
  stall_mode_t stall_mode      = STALL_NONE;
  int          stall_window    = 0;
  int          stall_run       = 0;
  bit          stall_level     = 1'b0;

  chs_sector_address_translator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Applies one word to the held position and returns the address word it yields
  function automatic out_word_t translate_next_position(input in_word_t w);
    int              lspt;
    int              lheads;
    int              pspt;
    int              nxt;
    bit              bad;
    longint unsigned linear;
    longint unsigned addr;
    longint unsigned used;
    longint unsigned amask;
    out_word_t       r;
    lspt   = int'(geo_lspt);
    lheads = int'(geo_lheads);
    pspt   = int'(geo_pspt);
    amask  = (64'd1 << ADDRESS_BITS) - 64'd1;
    addr   = 64'd0;
    if (w.kind == KIND_LOAD) begin
      pos_cyl  = w.load_cylinder;
      pos_head = w.load_head;
      pos_sect = w.load_sector;
    end else begin
      nxt = int'(pos_sect) + 1;
      if (nxt == lspt + 1) begin
        pos_sect = 8'd1;
        nxt = int'(pos_head) + 1;
        if (nxt == lheads) begin
          pos_head = '0;
          pos_cyl  = pos_cyl + 16'd1;
        end else begin
          pos_head = nxt[HEAD_W-1:0];
        end
      end else begin
        pos_sect = nxt[SECT_W-1:0];
      end
    end
    bad = (int'(pos_head) >= lheads) || (pos_sect == '0) || (int'(pos_sect) > lspt);
    if (!bad) begin
      linear = 64'((longint'(pos_cyl) * longint'(lheads) + longint'(pos_head)) *
                   longint'(lspt) + longint'(pos_sect) - longint'(1));
      if (geo_lspt != geo_pspt || geo_lheads != geo_pheads) begin
        if (pspt < 2) begin
          bad = 1'b1;
        end else begin
          used = 64'(pspt - 1);
          addr = (linear / used) * 64'(pspt) + linear % used;
        end
      end else begin
        addr = linear;
      end
      if (addr > amask) bad = 1'b1;
    end
    r.cur_cylinder   = pos_cyl;
    r.cur_head       = pos_head;
    r.cur_sector     = pos_sect;
    r.sector_address = bad ? '0 : addr[ADDRESS_BITS-1:0];
    r.out_of_range   = bad;
    return r;
  endfunction

  function automatic in_word_t load_word(input int cyl, input int head, input int sect);
    in_word_t w;
    w.kind          = KIND_LOAD;
    w.load_cylinder = cyl[CYL_W-1:0];
    w.load_head     = head[HEAD_W-1:0];
    w.load_sector   = sect[SECT_W-1:0];
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.kind          = 1'($urandom_range(0, 1));
    w.load_cylinder = CYL_W'($urandom_range(0, 65535));
    w.load_head     = HEAD_W'($urandom_range(0, 15));
    w.load_sector   = SECT_W'($urandom_range(0, 255));
    return w;
  endfunction

  // Load fields of a step word carry noise that the block must ignore
  function automatic in_word_t step_word();
    in_word_t w;
    w      = random_word();
    w.kind = KIND_STEP;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_traffic ? 0 : $urandom_range(0, 6);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    pending_addresses.push_back(translate_next_position(w));
    words_sent++;
    burst_left--;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_addresses.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_LOG_SPT:   geo_lspt   = value[SPT_W-1:0];
      CFG_LOG_HEADS: geo_lheads = value[HEADS_W-1:0];
      CFG_PHY_SPT:   geo_pspt   = value[SPT_W-1:0];
      CFG_PHY_HEADS: geo_pheads = value[HEADS_W-1:0];
      default: ;
    endcase
  endtask

  // Only called with the block idle
  task automatic write_geometry(input int lspt, input int lheads,
                                input int pspt, input int pheads);
    write_register(CFG_LOG_SPT, lspt);
    write_register(CFG_LOG_HEADS, lheads);
    write_register(CFG_PHY_SPT, pspt);
    write_register(CFG_PHY_HEADS, pheads);
    @(negedge clk);
    cfg_we <= 1'b0;
    geometries_used++;
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_window == 0) begin
        stall_mode   = stall_mode_t'($urandom_range(0, 2));
        stall_window = $urandom_range(20, 200);
      end
      stall_window--;
      case (stall_mode)
        STALL_NONE:      stall_level = 1'b0;
        STALL_SCATTERED: stall_level = ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run == 0) begin
            stall_level = ~stall_level;
            stall_run   = $urandom_range(1, 20);
          end
          stall_run--;
        end
      endcase
      out_stall <= stall_level && !steady_traffic;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_addresses.size() == 0) begin
        $error("output word with nothing outstanding");
        mismatches++;
      end else begin
        oldest_address = pending_addresses.pop_front();
        results_checked++;
        if (oldest_address.out_of_range) flagged_results++;
        if (out_data.cur_cylinder !== oldest_address.cur_cylinder) begin
          $error("cur_cylinder: expected %0d, got %0d",
                 oldest_address.cur_cylinder, out_data.cur_cylinder);
          mismatches++;
        end
        if (out_data.cur_head !== oldest_address.cur_head) begin
          $error("cur_head: expected %0d, got %0d",
                 oldest_address.cur_head, out_data.cur_head);
          mismatches++;
        end
        if (out_data.cur_sector !== oldest_address.cur_sector) begin
          $error("cur_sector: expected %0d, got %0d",
                 oldest_address.cur_sector, out_data.cur_sector);
          mismatches++;
        end
        if (out_data.sector_address !== oldest_address.sector_address) begin
          $error("sector_address: expected %0d, got %0d",
                 oldest_address.sector_address, out_data.sector_address);
          mismatches++;
        end
        if (out_data.out_of_range !== oldest_address.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d",
                 oldest_address.out_of_range, out_data.out_of_range);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_position();
    send_word(step_word());
    send_word(load_word(65535, 15, 17));
  endtask

  task automatic test_track_wraps();
    send_word(load_word(5, 15, 17));
    send_word(step_word());
    send_word(load_word(65535, 15, 17));
    send_word(step_word());
    send_word(load_word(100, 3, 17));
    send_word(step_word());
  endtask

  task automatic test_out_of_range();
    send_word(load_word(12, 0, 0));
    send_word(load_word(12, 0, 18));
    // sector counts past 255 to 0 and stays out of range
    send_word(load_word(0, 0, 255));
    send_word(step_word());
    wait_for_results();
    write_geometry(17, 10, 17, 10);
    send_word(load_word(7, 12, 1));
    send_word(load_word(7, 9, 17));
    send_word(step_word());
    // head beyond the count wraps modulo 16 without a cylinder carry
    send_word(load_word(7, 15, 17));
    send_word(step_word());
    wait_for_results();
    write_geometry(17, 0, 17, 0);
    send_word(load_word(1, 0, 1));
    wait_for_results();
    write_geometry(0, 16, 0, 16);
    send_word(load_word(1, 0, 1));
    send_word(step_word());
  endtask

  task automatic test_translation();
    wait_for_results();
    write_geometry(63, 16, 17, 16);
    send_word(load_word(1000, 5, 40));
    wait_for_results();
    write_geometry(63, 16, 1, 16);
    send_word(load_word(1000, 5, 40));
    wait_for_results();
    write_geometry(63, 16, 0, 16);
    send_word(load_word(1000, 5, 40));
    // heads alone differ, physical heads zero
    wait_for_results();
    write_geometry(17, 16, 17, 0);
    send_word(load_word(3, 2, 5));
  endtask

  // Mostly legal loads followed by runs of steps, with some raw noise
  task automatic run_random_traffic(input int word_count);
    int sent;
    int lspt;
    int hmax;
    int cyl;
    int head;
    int sect;
    int steps;
    int pick;
    lspt = int'(geo_lspt);
    hmax = (geo_lheads > 16) ? 16 : int'(geo_lheads);
    sent = 0;
    while (sent < word_count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_word(random_word());
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0:       cyl = 0;
          1:       cyl = 65535;
          default: cyl = $urandom_range(0, 65535);
        endcase
        head = ($urandom_range(0, 2) == 0) ? hmax - 1 : $urandom_range(0, hmax - 1);
        if ($urandom_range(0, 1) == 0)
          sect = $urandom_range((lspt > 4) ? lspt - 3 : 1, lspt);
        else
          sect = $urandom_range(1, lspt);
        send_word(load_word(cyl, head, sect));
        sent++;
        steps = $urandom_range(1, 24);
        while (steps > 0 && sent < word_count) begin
          send_word(step_word());
          sent++;
          steps--;
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int lspt;
    int lheads;
    for (phase = 0; phase < 6; phase++) begin
      wait_for_results();
      steady_traffic = (phase == 2);
      case (phase)
        0: write_geometry(17, 16, 17, 16);
        1: write_geometry(255, 16, 255, 16);
        2: write_geometry(1, 1, 2, 1);
        3: write_geometry(63, 16, 17, 16);
        4: write_geometry(255, 16, 2, 16);
        default: begin
          lspt   = $urandom_range(1, 255);
          lheads = $urandom_range(1, 16);
          if ($urandom_range(0, 1) == 0)
            write_geometry(lspt, lheads, lspt, lheads);
          else
            write_geometry(lspt, lheads, $urandom_range(2, 255), $urandom_range(1, 16));
        end
      endcase
      run_random_traffic(92);
    end
    steady_traffic = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_position();
    test_track_wraps();
    test_out_of_range();
    test_translation();
    test_random_traffic();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_addresses.size() != 0) begin
      $error("%0d address words never arrived", pending_addresses.size());
      mismatches++;
    end
    $display("Sent %0d position words across %0d geometries, translated and direct.",
             words_sent, geometries_used);
    $display("Checked %0d address words, %0d of them flagged out of range.",
             results_checked, flagged_results);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/chs_pkg.sv
rtl/core/chs_addr_unit.sv
rtl/core/chs_sector_address_translator.sv
verif/chs_sector_address_translator_tb.sv
